@@ rtl/sha256_pkg.sv @@
// SHA-256 shared package: round constants, initial hash values, a rotate helper function
// and the command struct between controller and datapath.
// No dependencies.
package sha256_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned Rounds = 64;
   localparam logic [7:0] PadByte = 8'h80;

   localparam logic [31:0] InitWords [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] RoundConsts [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // byte source for the buffer write port
   typedef enum logic [1:0] {
      BSRC_DATA = 2'd0,
      BSRC_PAD  = 2'd1,
      BSRC_ZERO = 2'd2,
      BSRC_LEN  = 2'd3
   } byte_src_type;

   typedef struct packed {
      logic         buf_wr;     // write one byte at buf_addr
      logic [5:0]   buf_addr;
      byte_src_type buf_src;
      logic [7:0]   data_byte;
      logic         load_vars;  // a..h <= chain words
      logic         load_word;  // load schedule word round_idx[3:0] from the buffer read word (t < 16)
      logic         round;      // run round round_idx
      logic [5:0]   round_idx;
      logic         fold;       // chain += a..h
      logic         snap_len;   // capture bit length
      logic         init;       // reinitialise chain words
   } dp_cmd_type;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
      ror32 = (x >> n) | (x << (32 - n));
   endfunction

endpackage

@@ rtl/sha256_datapath.sv @@
// SHA-256 datapath: block buffer memory, schedule window, working variables, chain words.
// Depends on sha256_pkg.
module sha256_datapath import sha256_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       cmd,
   input  logic [31:0]      block_total,
   input  logic [5:0]       fill_count,
   input  logic [2:0]       rd_index,
   output logic [31:0]      chain_word
);

   logic [31:0] buf_mem [BlockBytes / 4];
   logic [31:0] rd_word_ff;
   logic [31:0] w_ff [16];
   logic [31:0] v_ff [8];
   logic [31:0] chain_ff [8];
   logic [63:0] len_ff;
   logic [7:0]  wr_byte;
   logic [31:0] w_cur, s0, s1, sig0, sig1, ch, maj, t1, t2, w_new;
   logic [3:0]  t4;
   logic [5:0]  rd_addr;

   always_comb begin
      case (cmd.buf_src)
         BSRC_DATA: wr_byte = cmd.data_byte;
         BSRC_PAD:  wr_byte = PadByte;
         BSRC_ZERO: wr_byte = 8'h00;
         default:   wr_byte = len_ff[8 * (7 - 32'(cmd.buf_addr[2:0])) +: 8];
      endcase
   end

   // buffer held as big-endian words: write one byte lane, read one whole word;
   // the read word is registered, so the controller addresses word t before it stores it
   assign rd_addr = cmd.buf_addr;
   always_ff @(posedge clock) begin
      if (cmd.buf_wr) begin
         buf_mem[cmd.buf_addr[5:2]][8 * (3 - 32'(cmd.buf_addr[1:0])) +: 8] <= wr_byte;
      end
      rd_word_ff <= buf_mem[rd_addr[5:2]];
   end

   assign t4 = cmd.round_idx[3:0];
   always_comb begin
      s1 = ror32(w_ff[t4 - 4'd2], 17) ^ ror32(w_ff[t4 - 4'd2], 19) ^ (w_ff[t4 - 4'd2] >> 10);
      s0 = ror32(w_ff[t4 - 4'd15], 7) ^ ror32(w_ff[t4 - 4'd15], 18) ^ (w_ff[t4 - 4'd15] >> 3);
      w_new = s1 + w_ff[t4 - 4'd7] + s0 + w_ff[t4];
      w_cur = (cmd.round_idx < 6'd16) ? w_ff[t4] : w_new;
      sig1 = ror32(v_ff[4], 6) ^ ror32(v_ff[4], 11) ^ ror32(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      sig0 = ror32(v_ff[0], 2) ^ ror32(v_ff[0], 13) ^ ror32(v_ff[0], 22);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1 = v_ff[7] + sig1 + ch + RoundConsts[cmd.round_idx] + w_cur;
      t2 = sig0 + maj;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_word) begin
         w_ff[cmd.round_idx[3:0]] <= rd_word_ff;
      end
      if (cmd.snap_len) begin
         len_ff <= {26'd0, block_total, fill_count} << 3;
      end
      if (cmd.load_vars) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= chain_ff[i];
      end else if (cmd.round) begin
         if (cmd.round_idx >= 6'd16) w_ff[t4] <= w_new;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.init) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= InitWords[i];
      end else if (cmd.fold) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + v_ff[i];
      end
   end

   assign chain_word = chain_ff[rd_index];

endmodule

@@ rtl/sha256_controller.sv @@
// SHA-256 controller: byte intake, padding sequence, round sequencing, digest output.
// Depends on sha256_pkg.
module sha256_controller import sha256_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic        in_kind,
   input  logic [7:0]  in_byte,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [2:0]  out_index,
   output dp_cmd_type  cmd,
   output logic [31:0] block_total,
   output logic [5:0]  fill_count
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_PAD   = 7'b0000010,
      ST_LOAD  = 7'b0000100,
      ST_ROUND = 7'b0001000,
      ST_FOLD  = 7'b0010000,
      ST_EMIT  = 7'b0100000,
      ST_INIT  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [31:0] total_ff, total_in;
   logic [6:0]  cnt_ff, cnt_in;     // load/round step
   logic        fin_ff, fin_in;     // finishing a message
   logic        last_ff, last_in;   // current compression is the final one
   logic [2:0]  idx_ff, idx_in;

   assign block_total = total_ff;
   assign fill_count  = fill_ff;
   assign in_ready    = (state_ff == ST_IDLE);
   assign out_valid   = (state_ff == ST_EMIT);
   assign out_index   = idx_ff;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      cnt_in   = cnt_ff;
      fin_in   = fin_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.data_byte = in_byte;
      cmd.buf_src   = BSRC_DATA;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               if (!in_kind) begin
                  cmd.buf_wr   = 1'b1;
                  cmd.buf_addr = fill_ff;
                  fill_in      = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     total_in = total_ff + 32'd1;
                     last_in  = 1'b0;
                     cnt_in   = '0;
                     state_in = ST_LOAD;
                  end
               end else begin
                  cmd.buf_wr   = 1'b1;
                  cmd.buf_addr = fill_ff;
                  cmd.buf_src  = BSRC_PAD;
                  cmd.snap_len = 1'b1;
                  fin_in       = 1'b1;
                  last_in      = (fill_ff < 6'd56);
                  fill_in      = fill_ff + 6'd1;
                  state_in     = (fill_ff == 6'd63) ? ST_LOAD : ST_PAD;
                  cnt_in       = '0;
               end
            end
         end
         ST_PAD: begin
            // zeros, then the length field if final; else zeros to the block end
            cmd.buf_wr   = 1'b1;
            cmd.buf_addr = fill_ff;
            cmd.buf_src  = (last_ff && fill_ff >= 6'd56) ? BSRC_LEN : BSRC_ZERO;
            fill_in      = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               cnt_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // word read lead: cnt 0 reads word 0, later cycles store previous word
            cmd.buf_addr = {cnt_ff[3:0], 2'd0};
            cmd.round_idx = 6'(cnt_ff - 7'd1);
            cmd.load_word = (cnt_ff != 7'd0);
            if (cnt_ff == 7'd0) cmd.load_vars = 1'b1;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd16) begin
               cnt_in   = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round     = 1'b1;
            cmd.round_idx = cnt_ff[5:0];
            cnt_in        = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            fill_in  = '0;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (!last_ff) begin
               last_in  = 1'b1;
               state_in = ST_PAD;
            end else begin
               idx_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            fill_in  = '0;
            total_in = '0;
            fin_in   = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         total_ff <= '0;
         cnt_ff   <= '0;
         fin_ff   <= 1'b0;
         last_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         cnt_ff   <= cnt_in;
         fin_ff   <= fin_in;
         last_ff  <= last_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

@@ rtl/sha256_stream_hasher.sv @@
// SHA-256 over a byte stream. Every 64th message byte starts a compression:
// a load of the sixteen schedule words, 64 rounds (one round per cycle through
// a single shared round unit) and a fold, during which no beat is taken. A
// finish beat adds padding, one or two compressions, then eight digest beats,
// most significant word first, and a reinitialisation of the chain words.
// Depends on sha256_pkg, sha256_controller, sha256_datapath.
module sha256_stream_hasher import sha256_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] kind: 0 byte, 1 finish
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, [39:35] zero
   output logic        rsp_tlast    // last_word
);

   dp_cmd_type  cmd;
   logic [31:0] block_total;
   logic [5:0]  fill_count;
   logic [2:0]  out_index;
   logic [31:0] chain_word;

   sha256_controller u_ctrl (
      .clock, .reset,
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_kind  (req_tuser),
      .in_byte  (req_tdata),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_index,
      .cmd,
      .block_total,
      .fill_count
   );

   sha256_datapath u_dp (
      .clock, .reset,
      .cmd,
      .block_total,
      .fill_count,
      .rd_index  (out_index),
      .chain_word
   );

   // hold the digest word stable while the beat is stalled: the chain only changes on fold/init
   assign rsp_tdata = {5'd0, out_index, chain_word};
   assign rsp_tlast = (out_index == 3'd7);

endmodule

@@ rtl/sha256_stream_hasher_checker.sv @@
// Port-level checker for sha256_stream_hasher, bound to the top level.
// No dependencies.
module sha256_stream_hasher_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   // never take a beat while a digest is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input open during digest");

   // last flag matches the word index
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[34:32] == 3'd7))) else $error("tlast mismatch");

   // word index advances by one after each non-final beat
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1)
      else $error("index skip");

   // a stalled beat holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("payload changed under stall");

endmodule

bind sha256_stream_hasher sha256_stream_hasher_checker u_checker (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
);
